>>> hw/rtl/fastcgi_response_deframer_assert.svh
// Assertion macros shared by the deframer RTL files.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FASTCGI_RESPONSE_DEFRAMER_ASSERT_SVH
`define FASTCGI_RESPONSE_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define FCGI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define FCGI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define FCGI_ASSERT(label, prop, msg)
`define FCGI_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> hw/rtl/fcgi_pkg.sv
// Types and constants for the FastCGI response deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package fcgi_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CONTENT,
    PH_PADDING,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    KIND_STDOUT   = 3'd0,
    KIND_STDERR   = 3'd1,
    KIND_COMPLETE = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_CLOSED   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_VERSION = 3'd1,
    CAUSE_REQ_ID  = 3'd2,
    CAUSE_TYPE    = 3'd3,
    CAUSE_STATUS  = 3'd4,
    CAUSE_SHORT   = 3'd5
  } cause_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_REQ_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN   = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Record header fields
  localparam logic [2:0]  HDR_VERSION  = 3'd0;
  localparam logic [2:0]  HDR_TYPE     = 3'd1;
  localparam logic [2:0]  HDR_ID_HI    = 3'd2;
  localparam logic [2:0]  HDR_ID_LO    = 3'd3;
  localparam logic [2:0]  HDR_LEN_HI   = 3'd4;
  localparam logic [2:0]  HDR_LEN_LO   = 3'd5;
  localparam logic [2:0]  HDR_PAD      = 3'd6;
  localparam logic [2:0]  HDR_RESERVED = 3'd7;

  localparam logic [7:0]  FCGI_VERSION = 8'd1;
  localparam logic [7:0]  TYPE_END     = 8'd3;
  localparam logic [7:0]  TYPE_STDOUT  = 8'd6;
  localparam logic [7:0]  TYPE_STDERR  = 8'd7;
  localparam logic [15:0] END_BODY_MIN = 16'd8;

  // End body: four status bytes, then the protocol status byte
  localparam logic [2:0]  BODY_PROTO   = 3'd4;
  localparam logic [2:0]  BODY_SAT     = 3'd5;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [31:0] exit_code;
    logic [7:0]  proto_code;
    cause_e      cause;
  } event_t;

endpackage

>>> hw/rtl/fcgi_front.sv
// Front end of the deframer: record header parser and classifier.
// Turns each accepted word into at most one event. Uses fcgi_pkg.
`timescale 1ns / 1ps
`include "fastcgi_response_deframer_assert.svh"
module fcgi_front
  import fcgi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  take_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_of_response_i,
  input  logic                  link_closed_i,
  output logic                  ev_valid_o,
  output event_t                ev_o
);

  logic [15:0] exp_id_q;
  logic        check_en_q;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  rec_type_q, rec_type_d;
  logic [7:0]  id_hi_q, id_hi_d;
  logic [15:0] content_q, content_d;
  logic [7:0]  padding_q, padding_d;
  logic [2:0]  body_idx_q, body_idx_d;
  logic [31:0] status_word_q, status_word_d;
  logic [7:0]  status_byte_q, status_byte_d;

  phase_e      eff_phase;
  logic [2:0]  eff_idx;
  logic        is_stream;
  logic        is_end;
  logic        version_bad;
  logic        id_bad;
  logic [15:0] content_dec;
  logic [7:0]  padding_dec;
  logic [31:0] sw_nxt;
  logic [7:0]  sb_nxt;
  logic        ev_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q   <= 16'd1;
      check_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXP_REQ_ID: exp_id_q   <= cfg_wdata_i;
        CFG_CHECK_EN:   check_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Shared decode of the current word
  always_comb begin
    eff_phase   = start_of_response_i ? PH_HEADER : phase_q;
    eff_idx     = start_of_response_i ? 3'd0 : hdr_idx_q;
    is_stream   = (rec_type_q == TYPE_STDOUT) || (rec_type_q == TYPE_STDERR);
    is_end      = (rec_type_q == TYPE_END);
    version_bad = check_en_q && (data_byte_i != FCGI_VERSION);
    id_bad      = check_en_q && ({id_hi_q, data_byte_i} != exp_id_q);
    content_dec = content_q - 16'd1;
    padding_dec = padding_q - 8'd1;
    sw_nxt      = status_word_q;
    sb_nxt      = status_byte_q;
    if (body_idx_q < BODY_PROTO) begin
      sw_nxt = {status_word_q[23:0], data_byte_i};
    end else if (body_idx_q == BODY_PROTO) begin
      sb_nxt = data_byte_i;
    end
  end

  // Next state
  always_comb begin
    phase_d       = phase_q;
    hdr_idx_d     = hdr_idx_q;
    rec_type_d    = rec_type_q;
    id_hi_d       = id_hi_q;
    content_d     = content_q;
    padding_d     = padding_q;
    body_idx_d    = body_idx_q;
    status_word_d = status_word_q;
    status_byte_d = status_byte_q;
    if (take_i) begin
      if (link_closed_i) begin
        phase_d = PH_DONE;
      end else begin
        unique case (eff_phase)
          PH_HEADER: begin
            phase_d   = PH_HEADER;
            hdr_idx_d = eff_idx + 3'd1;
            unique case (eff_idx)
              HDR_VERSION: if (version_bad) phase_d = PH_DONE;
              HDR_TYPE:    rec_type_d = data_byte_i;
              HDR_ID_HI:   id_hi_d = data_byte_i;
              HDR_ID_LO:   if (id_bad) phase_d = PH_DONE;
              HDR_LEN_HI:  content_d = {data_byte_i, 8'h00};
              HDR_LEN_LO:  content_d = {content_q[15:8], data_byte_i};
              HDR_PAD:     padding_d = data_byte_i;
              HDR_RESERVED: begin
                body_idx_d    = 3'd0;
                status_word_d = 32'd0;
                status_byte_d = 8'd0;
                if (is_stream) begin
                  if (content_q != 16'd0) begin
                    phase_d = PH_CONTENT;
                  end else if (padding_q != 8'd0) begin
                    phase_d = PH_PADDING;
                  end else begin
                    phase_d = PH_HEADER;
                  end
                end else if (is_end) begin
                  phase_d = (content_q < END_BODY_MIN) ? PH_DONE : PH_CONTENT;
                end else begin
                  phase_d = PH_DONE;
                end
              end
              default: ;
            endcase
          end
          PH_CONTENT: begin
            content_d = content_dec;
            if (is_end) begin
              status_word_d = sw_nxt;
              status_byte_d = sb_nxt;
              if (body_idx_q != BODY_SAT) body_idx_d = body_idx_q + 3'd1;
            end
            if (content_dec == 16'd0) begin
              if (padding_q != 8'd0) begin
                phase_d = PH_PADDING;
              end else begin
                phase_d = is_end ? PH_DONE : PH_HEADER;
              end
            end
          end
          PH_PADDING: begin
            padding_d = padding_dec;
            if (padding_dec == 8'd0) phase_d = is_end ? PH_DONE : PH_HEADER;
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  // Event output
  always_comb begin
    ev_valid_o      = 1'b0;
    ev_o.kind       = KIND_STDOUT;
    ev_o.payload    = 8'd0;
    ev_o.exit_code  = 32'd0;
    ev_o.proto_code = 8'd0;
    ev_o.cause      = CAUSE_NONE;
    if (take_i) begin
      if (link_closed_i) begin
        if (phase_q != PH_DONE) begin
          ev_valid_o = 1'b1;
          ev_o.kind  = KIND_CLOSED;
        end
      end else begin
        unique case (eff_phase)
          PH_HEADER: begin
            ev_o.kind = KIND_ERROR;
            if (eff_idx == HDR_VERSION && version_bad) begin
              ev_valid_o = 1'b1;
              ev_o.cause = CAUSE_VERSION;
            end else if (eff_idx == HDR_ID_LO && id_bad) begin
              ev_valid_o = 1'b1;
              ev_o.cause = CAUSE_REQ_ID;
            end else if (eff_idx == HDR_RESERVED && !is_stream) begin
              ev_valid_o = is_end ? (content_q < END_BODY_MIN) : 1'b1;
              ev_o.cause = is_end ? CAUSE_SHORT : CAUSE_TYPE;
            end
          end
          PH_CONTENT: begin
            if (is_stream) begin
              ev_valid_o   = 1'b1;
              ev_o.kind    = rec_type_q[0] ? KIND_STDERR : KIND_STDOUT;
              ev_o.payload = data_byte_i;
            end else if (content_dec == 16'd0 && padding_q == 8'd0) begin
              ev_valid_o      = 1'b1;
              ev_o.kind       = (sb_nxt == 8'd0) ? KIND_COMPLETE : KIND_ERROR;
              ev_o.cause      = (sb_nxt == 8'd0) ? CAUSE_NONE : CAUSE_STATUS;
              ev_o.exit_code  = sw_nxt;
              ev_o.proto_code = sb_nxt;
            end
          end
          PH_PADDING: begin
            if (padding_dec == 8'd0 && is_end) begin
              ev_valid_o      = 1'b1;
              ev_o.kind       = (status_byte_q == 8'd0) ? KIND_COMPLETE : KIND_ERROR;
              ev_o.cause      = (status_byte_q == 8'd0) ? CAUSE_NONE : CAUSE_STATUS;
              ev_o.exit_code  = status_word_q;
              ev_o.proto_code = status_byte_q;
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEADER;
      hdr_idx_q     <= 3'd0;
      rec_type_q    <= 8'd0;
      id_hi_q       <= 8'd0;
      content_q     <= 16'd0;
      padding_q     <= 8'd0;
      body_idx_q    <= 3'd0;
      status_word_q <= 32'd0;
      status_byte_q <= 8'd0;
    end else begin
      phase_q       <= phase_d;
      hdr_idx_q     <= hdr_idx_d;
      rec_type_q    <= rec_type_d;
      id_hi_q       <= id_hi_d;
      content_q     <= content_d;
      padding_q     <= padding_d;
      body_idx_q    <= body_idx_d;
      status_word_q <= status_word_d;
      status_byte_q <= status_byte_d;
    end
  end

  // A completion, an error or a close is the last event of a response.
  assign ev_final = ev_valid_o && (ev_o.kind == KIND_COMPLETE || ev_o.kind == KIND_ERROR ||
                                   ev_o.kind == KIND_CLOSED);

  `FCGI_ASSERT_NEXT(a_final_ends, ev_final, phase_q == PH_DONE, "final event left response open")

endmodule

>>> hw/rtl/fcgi_queue.sv
// Short event queue between the parser and the output stage.
// Register-based ring buffer; uses fcgi_pkg for the event type.
`timescale 1ns / 1ps
`include "fastcgi_response_deframer_assert.svh"
module fcgi_queue
  import fcgi_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output event_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  event_t            entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `FCGI_ASSERT(a_no_overflow, push_i |-> !full_o, "event pushed into a full queue")
  `FCGI_ASSERT(a_no_underflow, pop_i |-> !empty_o, "event popped from an empty queue")

endmodule

>>> hw/rtl/fcgi_back.sv
// Output stage of the deframer: holds one event for the result channel.
// Drains the event queue; uses fcgi_pkg for the event type.
`timescale 1ns / 1ps
module fcgi_back
  import fcgi_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_empty_i,
  input  event_t q_data_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output event_t out_data_o
);

  logic   valid_q, valid_d;
  event_t data_q;

  assign q_pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (valid_q && out_stall_i) begin
      valid_d = 1'b1;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) data_q <= q_data_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> hw/rtl/fastcgi_response_deframer.sv
// Top level of the FastCGI response deframer.
// Instantiates fcgi_front, fcgi_queue and fcgi_back; uses fcgi_pkg.
//
//   Channel   Direction   Handshake               Payload words
//   input     in          in_valid_i/in_stall_o   data_byte_i, start_of_response_i,
//                                                 link_closed_i
//   result    out         out_valid_o/out_stall_i kind_o, payload_o, exit_code_o,
//                                                 proto_code_o, error_cause_o
//   config    in          cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A word can be taken every cycle while the input is not stalled; the parser decides
// each word in the cycle it is accepted and pushes its result, if any, into a
// QueueDepth-entry queue. The result is written into the queue and from there into the
// registered output stage. The input stalls only while the queue is full, which needs
// QueueDepth + 1 results held up behind a stalled result side. Reset is asynchronous,
// active low, and returns the parser to the start of a record header.
`timescale 1ns / 1ps
`include "fastcgi_response_deframer_assert.svh"
module fastcgi_response_deframer
  import fcgi_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,

  // Input words from the backend link
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_of_response_i,
  input  logic                  link_closed_i,

  // Result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [7:0]            payload_o,
  output logic [31:0]           exit_code_o,
  output logic [7:0]            proto_code_o,
  output logic [2:0]            error_cause_o
);

  logic   in_take;
  logic   ev_valid;
  event_t ev;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  event_t q_data;
  event_t out_data;
  logic   stream_word;
  logic   status_clear;
  logic   cause_agrees;

  // The queue always has room for the event of an accepted word.
  assign in_stall_o = q_full;
  assign in_take    = in_valid_i && !in_stall_o;

  fcgi_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .take_i              (in_take),
    .data_byte_i         (data_byte_i),
    .start_of_response_i (start_of_response_i),
    .link_closed_i       (link_closed_i),
    .ev_valid_o          (ev_valid),
    .ev_o                (ev)
  );

  fcgi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .data_i  (ev),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  fcgi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign kind_o        = out_data.kind;
  assign payload_o     = out_data.payload;
  assign exit_code_o   = out_data.exit_code;
  assign proto_code_o  = out_data.proto_code;
  assign error_cause_o = out_data.cause;

  // Stream words carry only a content byte; error words always name a cause.
  assign stream_word  = out_valid_o && (kind_o == KIND_STDOUT || kind_o == KIND_STDERR);
  assign status_clear = (exit_code_o == 32'd0) && (proto_code_o == 8'd0) &&
                        (error_cause_o == CAUSE_NONE);
  assign cause_agrees = ((kind_o == KIND_ERROR) == (error_cause_o != CAUSE_NONE));

  `FCGI_ASSERT(a_stream_word_clean, stream_word |-> status_clear, "stream word has status fields")
  `FCGI_ASSERT(a_cause_matches_kind, out_valid_o |-> cause_agrees, "cause does not match kind")

endmodule
